[rtl/sjf_pkg.sv]
// Shared types, widths and defaults for the shortest-job-first scheduler.
package sjf_pkg;

    localparam int DEFAULT_MAX_JOBS = 32;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int CLK_W  = 22;
    localparam int SUM_W  = 27;
    localparam int JOBN_W = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_CALC,
        ST_SUM,
        ST_OUT
    } sjf_state_t;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic calc;
        logic sum;
        logic emit;
    } sjf_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic set_last;
    } sjf_stat_t;

endpackage

[rtl/sjf_ctrl.sv]
// Sequencer for loading, scanning, computing and emitting scheduled jobs.
module sjf_ctrl
    import sjf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      last_job,
    input  sjf_stat_t stat,
    output sjf_cmd_t  cmd,
    output logic      busy,
    output logic      valid
);

    sjf_state_t state_reg;
    sjf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        valid      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_job)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                valid    = 1'b1;
                cmd.emit = 1'b1;
                if (stat.set_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/sjf_datapath.sv]
// Job store, selection scan, time arithmetic and result registers.
module sjf_datapath
    import sjf_pkg::*;
#(
    parameter int MAX_JOBS = DEFAULT_MAX_JOBS,
    localparam int IW = $clog2(MAX_JOBS),
    localparam int CW = $clog2(MAX_JOBS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sjf_cmd_t          cmd,
    output sjf_stat_t         stat,
    input  logic [ARR_W-1:0]  arrival_time,
    input  logic [BUR_W-1:0]  burst_length,
    output logic [JOBN_W-1:0] job_number,
    output logic [ARR_W-1:0]  job_arrival,
    output logic [BUR_W-1:0]  job_burst,
    output logic [CLK_W-1:0]  wait_ticks,
    output logic [CLK_W-1:0]  turnaround_ticks,
    output logic [SUM_W-1:0]  wait_total,
    output logic [SUM_W-1:0]  turnaround_total,
    output logic              overflowed,
    output logic              final_result
);

    logic [ARR_W+BUR_W-1:0] mem [MAX_JOBS];

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       emit_cnt_reg;
    logic [IW-1:0]       addr_reg;
    logic [MAX_JOBS-1:0] done_reg;
    logic [CLK_W-1:0]    clock_reg;
    logic [SUM_W-1:0]    wait_sum_reg;
    logic [SUM_W-1:0]    turn_sum_reg;
    logic                ovf_reg;

    logic                rd_vld_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [ARR_W-1:0]    rd_arr_reg;
    logic [BUR_W-1:0]    rd_bur_reg;

    // best job already arrived, and earliest pending job as fallback
    logic                a_found_reg;
    logic [ARR_W-1:0]    a_arr_reg;
    logic [BUR_W-1:0]    a_bur_reg;
    logic [IW-1:0]       a_idx_reg;
    logic                e_found_reg;
    logic [ARR_W-1:0]    e_arr_reg;
    logic [BUR_W-1:0]    e_bur_reg;
    logic [IW-1:0]       e_idx_reg;

    logic [CLK_W-1:0]    wait_reg;
    logic [CLK_W-1:0]    turn_reg;
    logic [ARR_W-1:0]    sel_arr_reg;
    logic [BUR_W-1:0]    sel_bur_reg;
    logic [IW-1:0]       sel_idx_reg;

    logic [JOBN_W-1:0]   job_number_reg;
    logic [ARR_W-1:0]    job_arrival_reg;
    logic [BUR_W-1:0]    job_burst_reg;
    logic [CLK_W-1:0]    wait_ticks_reg;
    logic [CLK_W-1:0]    turn_ticks_reg;
    logic [SUM_W-1:0]    wait_total_reg;
    logic [SUM_W-1:0]    turn_total_reg;
    logic                overflowed_reg;
    logic                final_reg;

    logic                full;
    logic                cand;
    logic                arrived;
    logic                a_better;
    logic                e_better;
    logic [ARR_W-1:0]    s_arr;
    logic [BUR_W-1:0]    s_bur;
    logic [IW-1:0]       s_idx;
    logic [CLK_W-1:0]    s_start;
    logic [SUM_W-1:0]    wait_sum_next;
    logic [SUM_W-1:0]    turn_sum_next;

    assign full = (count_reg == CW'(MAX_JOBS));
    assign stat.scan_last = (CW'(addr_reg) == count_reg - CW'(1));
    assign stat.set_last  = (emit_cnt_reg == count_reg - CW'(1));

    // job store
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem[count_reg[IW-1:0]] <= {arrival_time, burst_length};
        end
        {rd_arr_reg, rd_bur_reg} <= mem[addr_reg];
        rd_idx_reg <= addr_reg;
    end

    assign cand     = rd_vld_reg && !done_reg[rd_idx_reg];
    assign arrived  = (CLK_W'(rd_arr_reg) <= clock_reg);
    assign a_better = !a_found_reg || (rd_bur_reg < a_bur_reg)
                      || ((rd_bur_reg == a_bur_reg) && (rd_arr_reg < a_arr_reg));
    assign e_better = !e_found_reg || (rd_arr_reg < e_arr_reg)
                      || ((rd_arr_reg == e_arr_reg) && (rd_bur_reg < e_bur_reg));

    always_comb
    begin
        if (a_found_reg)
        begin
            s_arr   = a_arr_reg;
            s_bur   = a_bur_reg;
            s_idx   = a_idx_reg;
            s_start = clock_reg;
        end
        else
        begin
            s_arr   = e_arr_reg;
            s_bur   = e_bur_reg;
            s_idx   = e_idx_reg;
            s_start = CLK_W'(e_arr_reg);
        end
    end

    assign wait_sum_next = wait_sum_reg + SUM_W'(wait_reg);
    assign turn_sum_next = turn_sum_reg + SUM_W'(turn_reg);

    // scan candidates and calc/sum payload stages
    always_ff @(posedge clk)
    begin
        if (cand && arrived && a_better)
        begin
            a_arr_reg <= rd_arr_reg;
            a_bur_reg <= rd_bur_reg;
            a_idx_reg <= rd_idx_reg;
        end
        if (cand && e_better)
        begin
            e_arr_reg <= rd_arr_reg;
            e_bur_reg <= rd_bur_reg;
            e_idx_reg <= rd_idx_reg;
        end
        if (cmd.calc)
        begin
            wait_reg    <= s_start - CLK_W'(s_arr);
            turn_reg    <= s_start + CLK_W'(s_bur) - CLK_W'(s_arr);
            sel_arr_reg <= s_arr;
            sel_bur_reg <= s_bur;
            sel_idx_reg <= s_idx;
        end
        if (cmd.sum)
        begin
            job_number_reg  <= JOBN_W'(sel_idx_reg);
            job_arrival_reg <= sel_arr_reg;
            job_burst_reg   <= sel_bur_reg;
            wait_ticks_reg  <= wait_reg;
            turn_ticks_reg  <= turn_reg;
            wait_total_reg  <= wait_sum_next;
            turn_total_reg  <= turn_sum_next;
            overflowed_reg  <= ovf_reg;
            final_reg       <= stat.set_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            emit_cnt_reg <= '0;
            addr_reg     <= '0;
            done_reg     <= '0;
            clock_reg    <= '0;
            wait_sum_reg <= '0;
            turn_sum_reg <= '0;
            ovf_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            a_found_reg  <= 1'b0;
            e_found_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.scan_step)
            begin
                addr_reg <= addr_reg + IW'(1);
            end
            if (cand && arrived)
            begin
                a_found_reg <= 1'b1;
            end
            if (cand)
            begin
                e_found_reg <= 1'b1;
            end
            if (cmd.calc)
            begin
                clock_reg          <= s_start + CLK_W'(s_bur);
                done_reg[s_idx]    <= 1'b1;
            end
            if (cmd.sum)
            begin
                wait_sum_reg <= wait_sum_next;
                turn_sum_reg <= turn_sum_next;
            end
            if (cmd.scan_init)
            begin
                addr_reg    <= '0;
                a_found_reg <= 1'b0;
                e_found_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                emit_cnt_reg <= emit_cnt_reg + CW'(1);
                if (stat.set_last)
                begin
                    count_reg    <= '0;
                    emit_cnt_reg <= '0;
                    done_reg     <= '0;
                    clock_reg    <= '0;
                    wait_sum_reg <= '0;
                    turn_sum_reg <= '0;
                    ovf_reg      <= 1'b0;
                end
            end
        end
    end

    assign job_number       = job_number_reg;
    assign job_arrival      = job_arrival_reg;
    assign job_burst        = job_burst_reg;
    assign wait_ticks       = wait_ticks_reg;
    assign turnaround_ticks = turn_ticks_reg;
    assign wait_total       = wait_total_reg;
    assign turnaround_total = turn_total_reg;
    assign overflowed       = overflowed_reg;
    assign final_result     = final_reg;

endmodule

[rtl/sjf_nonpreemptive_scheduler.sv]
// Top level of the non-preemptive shortest-job-first scheduler.
// Usage: drive arrival_time, burst_length and last_job with start high; the item is
// taken at a rising edge where start is high and busy is low. An item with
// last_job low only stores the job and busy stays low. Jobs beyond
// MAX_JOBS are dropped and flag overflowed on every result of that set.
// An item with last_job high (stored or dropped) starts scheduling: busy rises
// and one result per stored job follows in schedule order, each shown for one
// cycle with valid high. Each decision scans the job store through its single
// read port, one job per cycle, over every job stored in the set.
// final_result marks the last result; busy falls after it and the set state
// is cleared for the next set. The receiver cannot stall: results must be
// taken in the cycle they are shown. Reset clears the set state and returns
// the block to idle; the job store needs no clearing.
module sjf_nonpreemptive_scheduler
    import sjf_pkg::*;
#(
    parameter int MAX_JOBS = DEFAULT_MAX_JOBS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ARR_W-1:0]  arrival_time,
    input  logic [BUR_W-1:0]  burst_length,
    input  logic              last_job,
    output logic              valid,
    output logic [JOBN_W-1:0] job_number,
    output logic [ARR_W-1:0]  job_arrival,
    output logic [BUR_W-1:0]  job_burst,
    output logic [CLK_W-1:0]  wait_ticks,
    output logic [CLK_W-1:0]  turnaround_ticks,
    output logic [SUM_W-1:0]  wait_total,
    output logic [SUM_W-1:0]  turnaround_total,
    output logic              overflowed,
    output logic              final_result
);

    sjf_cmd_t  cmd;
    sjf_stat_t stat;

    sjf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_job (last_job),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .valid    (valid)
    );

    sjf_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .arrival_time     (arrival_time),
        .burst_length     (burst_length),
        .job_number       (job_number),
        .job_arrival      (job_arrival),
        .job_burst        (job_burst),
        .wait_ticks       (wait_ticks),
        .turnaround_ticks (turnaround_ticks),
        .wait_total       (wait_total),
        .turnaround_total (turnaround_total),
        .overflowed       (overflowed),
        .final_result     (final_result)
    );

endmodule

[rtl/sjf_checker.sv]
// Port-level checks for the scheduler, bound to the top level.
module sjf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_job,
    input logic valid,
    input logic final_result
);

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result shown while not busy");

    a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobes back to back");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && final_result) |=> !busy)
        else $error("still busy after final result");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !final_result) |=> busy)
        else $error("idle before set finished");

    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_job) |=> (!busy && !valid))
        else $error("load item started work");

endmodule

bind sjf_nonpreemptive_scheduler sjf_checker u_sjf_checker (.*);
